[rtl/rpn_pkg.sv]
`default_nettype none
package rpn_pkg;

  localparam int DATA_W = 32;
  localparam int STEP_W = $clog2(DATA_W);

  localparam logic [2:0] FN_PUSH = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;
  localparam logic [2:0] FN_END  = 3'd5;

  localparam logic [2:0] ST_ACCEPT   = 3'd0;
  localparam logic [2:0] ST_FINAL    = 3'd1;
  localparam logic [2:0] ST_DIVZERO  = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // What one stack cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2
  } cell_op_t;

  typedef logic [DATA_W-1:0] word_t;

endpackage
`default_nettype wire

[rtl/rpn_cell.sv]
`default_nettype none
module rpn_cell
  import rpn_pkg::*;
(
  input  wire logic     clk,
  input  wire cell_op_t op,
  input  wire word_t    prev_data,
  input  wire word_t    next_data,
  output word_t         data
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_FROM_PREV: data <= prev_data;
      CELL_FROM_NEXT: data <= next_data;
      default:        data <= data;
    endcase
  end

endmodule
`default_nettype wire

[rtl/rpn_div.sv]
`default_nettype none
module rpn_div
  import rpn_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire word_t dividend,
  input  wire word_t divisor,
  output logic       busy,
  output word_t      quotient
);

  logic [STEP_W-1:0] step;
  word_t             rem;
  word_t             quo;
  word_t             dvs;
  logic              neg;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  always_comb begin
    trial = {rem, quo[DATA_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(DATA_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule
`default_nettype wire

[rtl/rpn_stack_evaluator.sv]
`default_nettype none
// Postfix evaluator on a stack of 32-bit integers held in a row of cells that
// shift as a whole: a push moves every entry one cell down, an operator moves
// them one cell up and drops its result into the top cell. Each item gives one
// result item. Push, add, subtract, multiply, end and error items finish on
// acceptance; a divide runs accept, 32 steps of the radix-2 divider and write
// back, so the divider sets the worst-case rate. An item is taken only when
// the output register is empty or being emptied in the same cycle.
module rpn_stack_evaluator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] func,
  input  wire logic signed [DATA_W-1:0] number,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      status,
  output logic signed [DATA_W-1:0] result_value
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  word_t            cell_q [STACK_DEPTH];
  cell_op_t         op_top, op_rest;
  word_t            top_din;
  word_t            lhs, rhs, res;
  word_t            div_q;
  logic             div_start, div_busy;
  logic             accept, out_free, ld_out;
  logic [2:0]       status_next;
  word_t            value_next;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t prev_d, next_d;
    if (i == 0) begin : g_first
      assign prev_d = top_din;
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end
    rpn_cell u_cell (
      .clk       (clk),
      .op        ((i == 0) ? op_top : op_rest),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[i])
    );
  end

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lhs),
    .divisor  (rhs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // Missing operands on a short stack read as zero.
  assign rhs = (count != '0) ? cell_q[0] : '0;
  assign lhs = (count >= CNT_W'(2)) ? cell_q[1] : '0;

  always_comb begin
    state_next  = state;
    count_next  = count;
    op_top      = CELL_HOLD;
    op_rest     = CELL_HOLD;
    top_din     = number;
    div_start   = 1'b0;
    ld_out      = 1'b0;
    status_next = ST_ACCEPT;
    value_next  = '0;
    res         = '0;
    if (accept) begin
      ld_out = 1'b1;
      unique case (func)
        FN_PUSH: begin
          if (count >= CNT_W'(STACK_DEPTH)) begin
            count_next  = '0;
            status_next = ST_OVERFLOW;
          end else begin
            op_top     = CELL_FROM_PREV;
            op_rest    = CELL_FROM_PREV;
            count_next = count + 1'b1;
            value_next = number;
          end
        end
        FN_ADD, FN_SUB, FN_MUL: begin
          unique case (func)
            FN_ADD:  res = lhs + rhs;
            FN_SUB:  res = lhs - rhs;
            default: res = DATA_W'(lhs * rhs);
          endcase
          top_din    = res;
          op_top     = CELL_FROM_PREV;
          op_rest    = CELL_FROM_NEXT;
          count_next = (count >= CNT_W'(2)) ? count - 1'b1 : CNT_W'(1);
          value_next = res;
        end
        FN_DIV: begin
          if (rhs == '0) begin
            count_next  = '0;
            status_next = ST_DIVZERO;
          end else begin
            ld_out     = 1'b0;
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
        FN_END: begin
          status_next = (count <= CNT_W'(1)) ? ST_FINAL : ST_INVALID;
          value_next  = (count == CNT_W'(1)) ? cell_q[0] : '0;
          count_next  = '0;
        end
        default: begin
          count_next  = '0;
          status_next = ST_INVALID;
        end
      endcase
    end else if (state == S_DIV && !div_busy && out_free) begin
      ld_out     = 1'b1;
      top_din    = div_q;
      op_top     = CELL_FROM_PREV;
      op_rest    = CELL_FROM_NEXT;
      count_next = (count >= CNT_W'(2)) ? count - 1'b1 : CNT_W'(1);
      value_next = div_q;
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      status       <= status_next;
      result_value <= value_next;
    end
  end

endmodule
`default_nettype wire
